// File: hdl/bal_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bal_pkg : shared types and constants for the bounded array list
// Sizes, request/response transaction structs, opcodes, error and cell codes.
// ----------------------------------------------------------------------------
package bal_pkg;

    localparam int CAPACITY   = 16;
    localparam int DATA_WIDTH = 32;

    // count holds 0..CAPACITY, index holds 0..CAPACITY-1
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int POS_W = 4;
    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    typedef logic [DATA_WIDTH-1:0] word_t;

    typedef struct packed {
        logic [2:0]         op;
        logic signed [31:0] data_in;
        logic [3:0]         position_in;
    } req_t;

    typedef struct packed {
        logic signed [31:0] data_out;
        logic               found;
        logic [3:0]         found_position;
        logic [1:0]         error_code;
        logic [4:0]         entry_count;
    } rsp_t;

    localparam logic [2:0] OP_APPEND    = 3'd0;
    localparam logic [2:0] OP_INSERT    = 3'd1;
    localparam logic [2:0] OP_TAKE_HEAD = 3'd2;
    localparam logic [2:0] OP_TAKE_TAIL = 3'd3;
    localparam logic [2:0] OP_TAKE_AT   = 3'd4;
    localparam logic [2:0] OP_READ_AT   = 3'd5;
    localparam logic [2:0] OP_FIND      = 3'd6;
    localparam logic [2:0] OP_CLEAR     = 3'd7;

    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_FULL  = 2'd1;
    localparam logic [1:0] ERR_RANGE = 2'd2;
    localparam logic [1:0] ERR_EMPTY = 2'd3;

    typedef logic [2:0] cell_cmd_t;

    localparam cell_cmd_t CELL_HOLD       = 3'd0;
    localparam cell_cmd_t CELL_LOAD       = 3'd1;
    localparam cell_cmd_t CELL_FROM_LOWER = 3'd2;
    localparam cell_cmd_t CELL_FROM_UPPER = 3'd3;
    localparam cell_cmd_t CELL_ZERO       = 3'd4;

    typedef struct packed {
        cell_cmd_t cmd;
        word_t     operand;
    } cell_ctrl_t;

endpackage

// File: hdl/bounded_array_list_top.sv
// Done rises in the cycle after start is taken, with the result registered.
// Throughput: one transaction per cycle; busy stays low, since every cell
//   shifts, loads or compares in the same cycle as its neighbours.
// Reset: all cells and the entry count clear at once; no sweep is needed.
// The receiver cannot stall: each result is valid for exactly one cycle.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_array_list_top : packed ordered list in a row of cells
// Decodes each request into per-cell commands, keeps the entry count and
// registers the response transaction.
// ----------------------------------------------------------------------------
module bounded_array_list_top (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  bal_pkg::req_t req,
    output logic          done,
    output bal_pkg::rsp_t rsp
);

    localparam int CAP   = bal_pkg::CAPACITY;
    localparam int CMP_W = bal_pkg::CMP_W;
    localparam int CNT_W = bal_pkg::CNT_W;
    localparam int IDX_W = bal_pkg::IDX_W;

    // ---- state -------------------------------------------------------------
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    bal_pkg::rsp_t    rsp_reg;
    bal_pkg::rsp_t    rsp_next;
    logic             done_reg;
    logic             done_next;

    logic             accept;

    // Row of cells: word and equality flag out of each slot
    bal_pkg::word_t      words [CAP];
    logic [CAP-1:0]      equal_vec;
    bal_pkg::cell_ctrl_t cell_ctrl [CAP];

    // ---- request decode ----------------------------------------------------
    bal_pkg::word_t   operand;
    logic [CMP_W-1:0] cnt;
    logic [CMP_W-1:0] pos;
    logic [CMP_W-1:0] rm_idx;
    logic             full;
    logic             empty;
    logic             app_ok;
    logic             ins_ok;
    logic             rm_ok;
    logic             clr;
    logic [IDX_W-1:0] rd_idx;

    assign accept  = start && !busy;
    assign operand = bal_pkg::DATA_WIDTH'(req.data_in);
    assign cnt     = CMP_W'(count_reg);
    assign pos     = CMP_W'(req.position_in);
    assign full    = (cnt >= CMP_W'(CAP));
    assign empty   = (cnt == '0);

    // Index of the slot leaving the list on a take
    always_comb
    begin
        unique case (req.op)
            bal_pkg::OP_TAKE_HEAD: rm_idx = '0;
            bal_pkg::OP_TAKE_TAIL: rm_idx = cnt - CMP_W'(1);
            default:               rm_idx = pos;
        endcase
    end

    assign app_ok = accept && (req.op == bal_pkg::OP_APPEND) && !full;
    assign ins_ok = accept && (req.op == bal_pkg::OP_INSERT) && !full && (pos <= cnt);
    assign rm_ok  = accept && !empty && rm_idx < cnt &&
                    (req.op == bal_pkg::OP_TAKE_HEAD ||
                     req.op == bal_pkg::OP_TAKE_TAIL ||
                     req.op == bal_pkg::OP_TAKE_AT);
    assign clr    = accept && (req.op == bal_pkg::OP_CLEAR);

    // ---- per-cell commands -------------------------------------------------
    // Insert opens a gap at pos by moving cells pos..count-1 up one slot;
    // a take closes the gap by pulling the upper neighbour down and zeroes
    // the slot that was last in use.
    for (genvar i = 0; i < CAP; i++)
    begin : g_ctrl
        logic [CMP_W-1:0] ic;
        assign ic = CMP_W'(i);

        always_comb
        begin
            cell_ctrl[i].operand = operand;
            if (clr)
                cell_ctrl[i].cmd = bal_pkg::CELL_ZERO;
            else if ((app_ok && ic == cnt) || (ins_ok && ic == pos))
                cell_ctrl[i].cmd = bal_pkg::CELL_LOAD;
            else if (ins_ok && ic > pos && ic <= cnt)
                cell_ctrl[i].cmd = bal_pkg::CELL_FROM_LOWER;
            else if (rm_ok && ic + CMP_W'(1) == cnt)
                cell_ctrl[i].cmd = bal_pkg::CELL_ZERO;
            else if (rm_ok && ic >= rm_idx && ic + CMP_W'(1) < cnt)
                cell_ctrl[i].cmd = bal_pkg::CELL_FROM_UPPER;
            else
                cell_ctrl[i].cmd = bal_pkg::CELL_HOLD;
        end
    end

    // ---- the row -----------------------------------------------------------
    for (genvar i = 0; i < CAP; i++)
    begin : g_cell
        bal_pkg::word_t lower_w;
        bal_pkg::word_t upper_w;

        if (i == 0)
        begin : g_first
            assign lower_w = '0;
        end
        else
        begin : g_inner_lo
            assign lower_w = words[i-1];
        end

        if (i == CAP - 1)
        begin : g_last
            assign upper_w = '0;
        end
        else
        begin : g_inner_hi
            assign upper_w = words[i+1];
        end

        bal_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (cell_ctrl[i]),
            .lower_word (lower_w),
            .upper_word (upper_w),
            .word       (words[i]),
            .equal      (equal_vec[i])
        );
    end

    // ---- find: lowest in-use cell that matches -----------------------------
    logic [CAP-1:0]   match_vec;
    logic             hit;
    logic [IDX_W-1:0] hit_idx;

    for (genvar i = 0; i < CAP; i++)
    begin : g_match
        assign match_vec[i] = equal_vec[i] && (CMP_W'(i) < cnt);
    end

    always_comb
    begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int k = CAP - 1; k >= 0; k--)
        begin
            if (match_vec[k])
            begin
                hit     = 1'b1;
                hit_idx = IDX_W'(k);
            end
        end
    end

    // ---- response and count ------------------------------------------------
    // Word at the read/take index (only used when that index is in range)
    assign rd_idx = (req.op == bal_pkg::OP_READ_AT) ? IDX_W'(pos) : IDX_W'(rm_idx);

    always_comb
    begin
        count_next = count_reg;
        rsp_next   = '0;

        unique case (req.op)
            bal_pkg::OP_APPEND:
            begin
                if (full)
                    rsp_next.error_code = bal_pkg::ERR_FULL;
                else
                    count_next = count_reg + CNT_W'(1);
            end
            bal_pkg::OP_INSERT:
            begin
                if (full)
                    rsp_next.error_code = bal_pkg::ERR_FULL;
                else if (pos > cnt)
                    rsp_next.error_code = bal_pkg::ERR_RANGE;
                else
                    count_next = count_reg + CNT_W'(1);
            end
            bal_pkg::OP_TAKE_HEAD, bal_pkg::OP_TAKE_TAIL, bal_pkg::OP_TAKE_AT:
            begin
                if (empty)
                    rsp_next.error_code = bal_pkg::ERR_EMPTY;
                else if (rm_idx >= cnt)
                    rsp_next.error_code = bal_pkg::ERR_RANGE;
                else
                begin
                    rsp_next.data_out = 32'($signed(words[rd_idx]));
                    count_next        = count_reg - CNT_W'(1);
                end
            end
            bal_pkg::OP_READ_AT:
            begin
                if (pos >= cnt)
                    rsp_next.error_code = bal_pkg::ERR_RANGE;
                else
                    rsp_next.data_out = 32'($signed(words[rd_idx]));
            end
            bal_pkg::OP_FIND:
            begin
                rsp_next.found          = hit;
                rsp_next.found_position = 4'(hit_idx);
            end
            default:
            begin
                count_next = '0;
            end
        endcase

        rsp_next.entry_count = 5'(count_next);
    end

    assign done_next = accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
            if (accept)
            begin
                count_reg <= count_next;
            end
        end
    end

    // Response payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign busy = 1'b0;
    assign done = done_reg;
    assign rsp  = rsp_reg;

    // ---- assertions --------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAP))
        else $error("entry count above capacity");

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("accepted transaction gave no result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> !done)
        else $error("result without a transaction");

    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> rsp.entry_count == 5'(count_reg))
        else $error("reported count differs from stored count");

    a_error_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.error_code != bal_pkg::ERR_OK |-> count_reg == $past(count_reg))
        else $error("failed request changed the count");

endmodule

// File: hdl/bal_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bal_cell : one slot of the list
// Holds a word, loads, shifts from a neighbour or clears; compares with key.
// ----------------------------------------------------------------------------
module bal_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  bal_pkg::cell_ctrl_t ctrl,
    input  bal_pkg::word_t      lower_word,
    input  bal_pkg::word_t      upper_word,
    output bal_pkg::word_t      word,
    output logic                equal
);

    bal_pkg::word_t word_reg;
    bal_pkg::word_t word_next;

    always_comb
    begin
        unique case (ctrl.cmd)
            bal_pkg::CELL_LOAD:       word_next = ctrl.operand;
            bal_pkg::CELL_FROM_LOWER: word_next = lower_word;
            bal_pkg::CELL_FROM_UPPER: word_next = upper_word;
            bal_pkg::CELL_ZERO:       word_next = '0;
            default:                  word_next = word_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg <= '0;
        end
        else
        begin
            word_reg <= word_next;
        end
    end

    assign word  = word_reg;
    assign equal = (word_reg == ctrl.operand);

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb : self-checking testbench for bounded_array_list_top
// Drives list requests through the start/busy handshake, keeps a shadow copy
// of the list, and compares every response transaction field by field.
// ----------------------------------------------------------------------------
module tb;

    // Number of request transactions to issue, directed part included.
    localparam int N_ITEMS = 850;
    // Longest idle gap the sender may draw between transactions.
    localparam int MAX_GAP = 13;

    // ------------------------------------------------------------------------
    // Shadow list and store of awaited responses.
    // note_request() applies an accepted request to the shadow list and
    // queues the response it must produce; check_response() compares the
    // response the block returned with the oldest one queued.
    // ------------------------------------------------------------------------
    class list_scoreboard;
        bal_pkg::word_t slot [bal_pkg::CAPACITY];
        int unsigned    fill;
        bal_pkg::rsp_t  awaited [$];
        int             n_fail;

        function new();
            foreach (slot[i])
                slot[i] = '0;
            fill   = 0;
            n_fail = 0;
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            n_fail++;
        endtask

        // Word as seen on data_out: sign-extended from the stored width.
        function logic signed [31:0] word_out(bal_pkg::word_t w);
            logic signed [bal_pkg::DATA_WIDTH-1:0] sw;
            sw = w;
            return 32'(sw);
        endfunction

        // Pull out the entry at idx, close the hole, zero the freed slot.
        function bal_pkg::word_t pull_entry(int unsigned idx);
            bal_pkg::word_t w;
            w = slot[idx];
            for (int unsigned i = idx; i + 1 < fill; i++)
                slot[i] = slot[i + 1];
            slot[fill - 1] = '0;
            fill--;
            return w;
        endfunction

        function bal_pkg::rsp_t list_response(bal_pkg::req_t r);
            bal_pkg::rsp_t  o;
            bal_pkg::word_t v;
            int unsigned    p;
            o = '0;
            v = bal_pkg::word_t'(r.data_in);
            p = 32'(r.position_in);
            case (r.op)
                bal_pkg::OP_APPEND:
                    if (fill >= bal_pkg::CAPACITY)
                        o.error_code = bal_pkg::ERR_FULL;
                    else
                    begin
                        slot[fill] = v;
                        fill++;
                    end
                bal_pkg::OP_INSERT:
                    // full is checked ahead of the index
                    if (fill >= bal_pkg::CAPACITY)
                        o.error_code = bal_pkg::ERR_FULL;
                    else if (p > fill)
                        o.error_code = bal_pkg::ERR_RANGE;
                    else
                    begin
                        for (int unsigned i = fill; i > p; i--)
                            slot[i] = slot[i - 1];
                        slot[p] = v;
                        fill++;
                    end
                bal_pkg::OP_TAKE_HEAD, bal_pkg::OP_TAKE_TAIL:
                    if (fill == 0)
                        o.error_code = bal_pkg::ERR_EMPTY;
                    else
                        o.data_out = word_out(pull_entry(
                            (r.op == bal_pkg::OP_TAKE_HEAD) ? 0 : fill - 1));
                bal_pkg::OP_TAKE_AT:
                    if (fill == 0)
                        o.error_code = bal_pkg::ERR_EMPTY;
                    else if (p >= fill)
                        o.error_code = bal_pkg::ERR_RANGE;
                    else
                        o.data_out = word_out(pull_entry(p));
                bal_pkg::OP_READ_AT:
                    // an empty list still reports a range error here
                    if (p >= fill)
                        o.error_code = bal_pkg::ERR_RANGE;
                    else
                        o.data_out = word_out(slot[p]);
                bal_pkg::OP_FIND:
                    for (int unsigned i = 0; i < fill; i++)
                        if (slot[i] == v)
                        begin
                            o.found          = 1'b1;
                            o.found_position = 4'(i);
                            break;
                        end
                default:
                begin
                    foreach (slot[i])
                        slot[i] = '0;
                    fill = 0;
                end
            endcase
            o.entry_count = 5'(fill);
            return o;
        endfunction

        function void note_request(bal_pkg::req_t r);
            awaited.push_back(list_response(r));
        endfunction

        task check_response(bal_pkg::rsp_t got);
            bal_pkg::rsp_t want;
            if (awaited.size() == 0)
            begin
                report("response with no request outstanding");
                return;
            end
            want = awaited.pop_front();
            if (got.data_out !== want.data_out)
                report($sformatf("data_out %0d, want %0d", got.data_out, want.data_out));
            if (got.found !== want.found)
                report($sformatf("found %b, want %b", got.found, want.found));
            if (got.found_position !== want.found_position)
                report($sformatf("found_position %0d, want %0d",
                                 got.found_position, want.found_position));
            if (got.error_code !== want.error_code)
                report($sformatf("error_code %0d, want %0d", got.error_code, want.error_code));
            if (got.entry_count !== want.entry_count)
                report($sformatf("entry_count %0d, want %0d",
                                 got.entry_count, want.entry_count));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the block itself
    // ------------------------------------------------------------------------
    logic          clk   = 1'b0;
    logic          rst_n = 1'b0;
    logic          start = 1'b0;
    bal_pkg::req_t req   = '0;
    logic          busy;
    logic          done;
    bal_pkg::rsp_t rsp;

    list_scoreboard sb = new();
    int    n_sent;
    bit    quiet;   // when set, transactions go back to back

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    bounded_array_list_top u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    // ------------------------------------------------------------------------
    // Monitor: everything is sampled on the rising edge. The response check
    // runs before the new request is noted, so a result is always matched
    // against requests accepted on earlier edges.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_response(rsp);
            if (start && !busy)
                sb.note_request(req);
        end
    end

    // ------------------------------------------------------------------------
    // Driver. Called on a falling edge, returns on the falling edge after the
    // transaction was taken. A zero gap keeps start high across transactions,
    // so start sees only one assignment per time step.
    // ------------------------------------------------------------------------
    task automatic send(logic [2:0] op, logic signed [31:0] value, logic [3:0] pos);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start           <= 1'b1;
        req.op          <= op;
        req.data_in     <= value;
        req.position_in <= pos;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
        n_sent++;
    endtask

    // Value mix: words already in the list (so find hits), extremes, a small
    // pool of repeats (duplicates make "lowest match" matter), and noise.
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return (sb.fill > 0) ? sb.word_out(sb.slot[$urandom_range(0, sb.fill - 1)])
                                    : 32'sd0;
            1:
                case ($urandom_range(0, 3))
                    0: return 32'sh7FFF_FFFF;
                    1: return 32'sh8000_0000;
                    2: return -32'sd1;
                    default: return 32'sd0;
                endcase
            2: return 32'($urandom_range(0, 7));
            default: return $urandom;
        endcase
    endfunction

    // Index mostly inside the list, now and then anywhere in the field.
    function automatic logic [3:0] pick_pos(int unsigned span);
        if ($urandom_range(0, 4) == 0)
            return 4'($urandom);
        return 4'($urandom_range(0, (span > 15) ? 15 : span));
    endfunction

    // One transaction of a given flavour:
    //   grow   - appends and inserts, runs into the full list
    //   shrink - takes from head, tail and index, runs into the empty list
    //   search - reads and finds
    //   mixed  - any operation, clear rarely
    //   noise  - every field fully random
    task automatic send_random(int flavour);
        logic [2:0] op;
        case (flavour)
            0, 1, 2:
            begin
                op = ($urandom_range(0, 1) == 0) ? bal_pkg::OP_APPEND : bal_pkg::OP_INSERT;
                send(op, pick_value(), pick_pos(sb.fill));
            end
            3, 4:
            begin
                case ($urandom_range(0, 2))
                    0: op = bal_pkg::OP_TAKE_HEAD;
                    1: op = bal_pkg::OP_TAKE_TAIL;
                    default: op = bal_pkg::OP_TAKE_AT;
                endcase
                send(op, $urandom, pick_pos((sb.fill > 0) ? sb.fill - 1 : 0));
            end
            5:
            begin
                op = ($urandom_range(0, 1) == 0) ? bal_pkg::OP_READ_AT : bal_pkg::OP_FIND;
                send(op, pick_value(), pick_pos((sb.fill > 0) ? sb.fill - 1 : 0));
            end
            6, 7, 8:
            begin
                op = 3'($urandom_range(0, 6));
                if ($urandom_range(0, 40) == 0)
                    op = bal_pkg::OP_CLEAR;
                send(op, pick_value(), pick_pos(sb.fill));
            end
            default:
                send(3'($urandom), $urandom, 4'($urandom));
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int flavour;
        int len;
        int waited;

        n_sent = 0;
        quiet  = 1'b0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: empty-list corner cases first
        send(bal_pkg::OP_READ_AT,   32'sd0, 4'd0);   // read on empty list: range error
        send(bal_pkg::OP_TAKE_HEAD, 32'sd0, 4'd0);   // take from empty list
        send(bal_pkg::OP_TAKE_TAIL, 32'sd0, 4'd0);
        send(bal_pkg::OP_TAKE_AT,   32'sd0, 4'd5);
        send(bal_pkg::OP_FIND,      32'sd0, 4'd0);   // zeroed slots must not match
        // Build a short list with the extreme words
        send(bal_pkg::OP_APPEND,    32'sh7FFF_FFFF, 4'd0);
        send(bal_pkg::OP_APPEND,    32'sh8000_0000, 4'd0);
        send(bal_pkg::OP_INSERT,    -32'sd1, 4'd0);  // insert at the head
        send(bal_pkg::OP_INSERT,    32'sd5, 4'd3);   // index equal to count appends
        send(bal_pkg::OP_INSERT,    32'sd9, 4'd15);  // insert past the end
        send(bal_pkg::OP_FIND,      32'sh8000_0000, 4'd0);  // hit
        send(bal_pkg::OP_FIND,      32'sd123, 4'd0); // miss
        send(bal_pkg::OP_READ_AT,   32'sd0, 4'd3);
        send(bal_pkg::OP_READ_AT,   32'sd0, 4'd15);  // index not below count
        send(bal_pkg::OP_TAKE_AT,   32'sd0, 4'd15);  // bad index on a non-empty list
        send(bal_pkg::OP_TAKE_AT,   32'sd0, 4'd1);
        send(bal_pkg::OP_TAKE_HEAD, 32'sd0, 4'd0);
        send(bal_pkg::OP_TAKE_TAIL, 32'sd0, 4'd0);
        send(bal_pkg::OP_APPEND,    32'sh5A5A_A5A5, 4'd0);
        send(bal_pkg::OP_CLEAR,     32'sd0, 4'd0);
        send(bal_pkg::OP_READ_AT,   32'sd0, 4'd0);   // slot freed by clear

        // Random episodes, each of one flavour, some of them without gaps
        while (n_sent < N_ITEMS)
        begin
            flavour = $urandom_range(0, 9);
            len     = $urandom_range(4, 40);
            quiet   = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < len && n_sent < N_ITEMS; k++)
                send_random(flavour);
        end
        start <= 1'b0;

        // Drain: wait until no response is still awaited
        waited = 0;
        while (sb.awaited.size() != 0 && waited < 100)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (4) @(posedge clk);
        if (sb.awaited.size() != 0)
            sb.report($sformatf("%0d responses never arrived", sb.awaited.size()));

        if (sb.n_fail == 0)
            $display("[bounded_array_list_top] OK");
        else
            $display("[bounded_array_list_top] ERROR");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #2_000_000;
        $display("[bounded_array_list_top] ERROR");
        $finish;
    end

endmodule

// File: bounded_array_list_top.f
hdl/bal_pkg.sv
hdl/bal_cell.sv
hdl/bounded_array_list_top.sv
tb/sv/tb.sv
